/* hdl/rlst_pkg.sv */
`default_nettype none
package rlst_pkg;
    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDX  = 2'd2;

    localparam int POS_BITS   = 32;
    localparam int RIDX_BITS  = 6;
    localparam int OSTY_BITS  = 8;
    localparam int OLEN_BITS  = 32;
    localparam int OCNT_BITS  = 7;
    localparam int ISTY_BITS  = 8;
endpackage
`default_nettype wire

/* hdl/rlst_ram.sv */
`default_nettype none
module rlst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/run_length_style_table_edit.sv */
// style run table editor, state held in two single-port-read rams (style, length)
// clear/append/unknown go straight to S_OUT; read first fetches the run via S_RWAIT
// insert and delete scan runs via S_SCAN/S_EDIT; delete moves later runs down via S_SHIFT/S_SHWR
// a delete that empties several runs moves the rest down each time
// one request at a time; a waiting result beat only holds the sequencer at its output step
// reset (synchronous, active low) empties the table; ram contents are not cleared
`default_nettype none
module run_length_style_table_edit
    import rlst_pkg::*;
#(
    parameter int MAX_RUNS    = 64,
    parameter int STYLE_BITS  = 8,
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [2:0]           i_action,
    input  wire logic [POS_BITS-1:0]  i_position,
    input  wire logic [POS_BITS-1:0]  i_amount,
    input  wire logic [POS_BITS-1:0]  i_end_position,
    input  wire logic [ISTY_BITS-1:0] i_style_index,
    input  wire logic [RIDX_BITS-1:0] i_run_index,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [1:0]                o_status,
    output logic [OCNT_BITS-1:0]      o_run_count,
    output logic [OSTY_BITS-1:0]      o_run_style,
    output logic [OLEN_BITS-1:0]      o_run_length
);
    localparam int AW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RWAIT = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EDIT  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_SHWR  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_SWAIT = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [2:0]             r_act;
    logic [POS_BITS-1:0]    r_p0, r_amt;
    logic [63:0]            r_pos, n_pos;       // start of the run being visited
    logic [63:0]            r_rem, n_rem;       // delete chars still to remove
    logic                   r_found, n_found;   // delete: first run located
    logic [CW-1:0]          r_idx, n_idx;       // run visited
    logic [CW-1:0]          r_k, n_k;           // shift cursor
    logic [1:0]             r_status, n_status;
    logic [STYLE_BITS-1:0]  r_ost;
    logic [LENGTH_BITS-1:0] r_olen;
    logic                   r_ovalid;

    logic                   we;
    logic [AW-1:0]          waddr, raddr;
    logic [STYLE_BITS-1:0]  wsty, rsty;
    logic [LENGTH_BITS-1:0] wlen, rlen;

    rlst_ram #(.WIDTH(STYLE_BITS), .DEPTH(MAX_RUNS)) u_sty (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wsty),
        .i_raddr(raddr), .o_rdata(rsty)
    );
    rlst_ram #(.WIDTH(LENGTH_BITS), .DEPTH(MAX_RUNS)) u_len (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wlen),
        .i_raddr(raddr), .o_rdata(rlen)
    );

    logic accept;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // result moves to the output register once that register is free or draining
    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_ready);

    // run end, saturating in 64 bits
    logic [64:0] end_sum;
    logic [63:0] seg_end;
    assign end_sum = {1'b0, r_pos} + {{(65-LENGTH_BITS){1'b0}}, rlen};
    assign seg_end = end_sum[64] ? '1 : end_sum[63:0];

    // saturating widen of the visited run
    logic [LENGTH_BITS:0]   wide_sum;
    logic [LENGTH_BITS-1:0] wide_len;
    logic [LENGTH_BITS-1:0] amt_len;
    assign amt_len  = (LENGTH_BITS >= POS_BITS)
                    ? LENGTH_BITS'(r_amt)
                    : ((|(r_amt >> LENGTH_BITS)) ? LEN_MAX : LENGTH_BITS'(r_amt));
    assign wide_sum = {1'b0, rlen} + {1'b0, amt_len};
    assign wide_len = wide_sum[LENGTH_BITS] ? LEN_MAX : wide_sum[LENGTH_BITS-1:0];

    // delete take on the visited run
    logic [63:0] offs, avail, take, rlen64;
    assign rlen64 = 64'(rlen);
    assign offs   = r_found ? 64'd0 : (64'(r_p0) - r_pos);
    assign avail  = rlen64 - offs;
    assign take   = (r_rem < avail) ? r_rem : avail;

    logic [LENGTH_BITS-1:0] len_in;
    assign len_in = (LENGTH_BITS >= POS_BITS)
                  ? LENGTH_BITS'(i_amount)
                  : ((|(i_amount >> LENGTH_BITS)) ? LEN_MAX : LENGTH_BITS'(i_amount));

    logic [STYLE_BITS-1:0] sty_in;
    assign sty_in = STYLE_BITS'(i_style_index);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_rem    = r_rem;
        n_found  = r_found;
        n_idx    = r_idx;
        n_k      = r_k;
        n_status = r_status;
        we       = 1'b0;
        waddr    = r_idx[AW-1:0];
        wsty     = rsty;
        wlen     = rlen;
        raddr    = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_pos    = '0;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_rem    = 64'(i_end_position) - 64'(i_position);
                    n_state  = S_OUT;
                    unique case (i_action)
                        ACT_CLEAR: n_count = '0;
                        ACT_APPEND: begin
                            if (r_count >= CW'(MAX_RUNS)) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                waddr   = r_count[AW-1:0];
                                wsty    = sty_in;
                                wlen    = len_in;
                                n_count = r_count + 1'b1;
                            end
                        end
                        ACT_INSERT: begin
                            if (r_count != '0 && i_amount != '0) begin
                                raddr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        ACT_DELETE: begin
                            if (r_count != '0 && i_position < i_end_position) begin
                                raddr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        ACT_READ: begin
                            if (CW'(i_run_index) >= r_count
                                    || 32'(i_run_index) >= 32'(MAX_RUNS)) begin
                                n_status = ST_IDX;
                            end else begin
                                raddr   = AW'(i_run_index);
                                n_state = S_RWAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RWAIT: n_state = S_OUT;
            S_SCAN: n_state = S_EDIT;   // ram data for r_idx arrives
            S_EDIT: begin
                if (r_act == ACT_INSERT) begin
                    if (64'(r_p0) < seg_end || r_idx == r_count - 1'b1) begin
                        we      = 1'b1;
                        wlen    = wide_len;
                        n_state = S_OUT;
                    end else begin
                        n_pos   = seg_end;
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN;
                    end
                end else if (!r_found && !(seg_end > 64'(r_p0))) begin
                    n_pos = seg_end;
                    n_idx = r_idx + 1'b1;
                    n_state = (r_idx + 1'b1 >= r_count) ? S_OUT : S_SCAN;
                end else begin
                    n_found = 1'b1;
                    n_rem   = r_rem - take;
                    if (rlen64 == take) begin
                        // run emptied: move later runs down
                        n_k = r_idx;
                        if (r_idx + 1'b1 >= r_count) begin
                            n_count = r_count - 1'b1;
                            n_state = S_OUT;
                        end else begin
                            raddr   = AW'(r_idx + 1'b1);
                            n_state = S_SHIFT;
                        end
                    end else begin
                        we    = 1'b1;
                        wlen  = LENGTH_BITS'(rlen64 - take);
                        n_idx = r_idx + 1'b1;
                        n_state = (r_rem == take || r_idx + 1'b1 >= r_count)
                                ? S_OUT : S_SCAN;
                    end
                end
            end
            S_SHIFT: begin
                raddr   = AW'(r_k + 1'b1);
                n_state = S_SHWR;
            end
            S_SHWR: begin
                we    = 1'b1;
                waddr = r_k[AW-1:0];
                n_k   = r_k + 1'b1;
                if (r_k + 2'd2 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = (r_rem == '0 || r_idx >= r_count - 1'b1)
                            ? S_OUT : S_SCAN;
                end else begin
                    raddr   = AW'(r_k + 2'd2);
                    n_state = S_SHIFT;
                end
            end
            // hold here while the previous result beat still waits
            S_OUT: n_state = out_load ? S_SWAIT : S_OUT;
            S_SWAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
            r_p0  <= i_position;
            r_amt <= i_amount;
        end
        r_pos    <= n_pos;
        r_rem    <= n_rem;
        r_found  <= n_found;
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_status <= n_status;
        if (r_state == S_RWAIT) begin
            r_ost  <= rsty;
            r_olen <= rlen;
        end else if (r_state == S_IDLE) begin
            r_ost  <= '0;
            r_olen <= '0;
        end
    end

    // result stays put while the edit unwinds; held in the output register
    logic [1:0]           r_ostat;
    logic [OCNT_BITS-1:0] r_ocnt;
    logic [OSTY_BITS-1:0] r_osty;
    logic [OLEN_BITS-1:0] r_olenq;
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ostat <= r_status;
            r_ocnt  <= OCNT_BITS'(r_count);
            r_osty  <= OSTY_BITS'(r_ost);
            r_olenq <= OLEN_BITS'(r_olen);
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostat;
    assign o_run_count  = r_ocnt;
    assign o_run_style  = r_osty;
    assign o_run_length = r_olenq;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RUNS)) else $error("run count beyond table size");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_run_count))
        else $error("result beat dropped");
`endif
endmodule
`default_nettype wire
